[sv/pps_pkg.sv]
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int QDEPTH = 2;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] EV_IDLE    = 2'd0;
  localparam logic [1:0] EV_RAN     = 2'd1;
  localparam logic [1:0] EV_ALLDONE = 2'd2;

  localparam logic [7:0] SWITCH_TIME_RST = 8'd1;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STEP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  proc_id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic        zero_burst;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  event_res;
    logic        switched;
    logic [15:0] switch_start;
    logic [3:0]  slot;
    logic [7:0]  run_id;
    logic [15:0] event_time;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] switch_count;
    logic [15:0] switch_total;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_EXEC
  } bstate_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage

[sv/pps_queue.sv]
module pps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pps_pkg::item_t  din,
  input  logic            pop,
  output pps_pkg::item_t  dout,
  output logic            empty,
  output logic            full
);

  localparam int PW = (pps_pkg::QDEPTH > 1) ? $clog2(pps_pkg::QDEPTH) : 1;
  localparam int CW = $clog2(pps_pkg::QDEPTH + 1);

  pps_pkg::item_t  entries [pps_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  logic do_push;
  logic do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(pps_pkg::QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(pps_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(pps_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

[sv/pps_front.sv]
module pps_front (
  input  logic            start,
  input  logic [1:0]      kind,
  input  logic [7:0]      proc_id,
  input  logic [15:0]     arrival_time,
  input  logic [15:0]     burst_time,
  input  logic [7:0]      priority_level,
  input  logic            q_full,
  output logic            busy,
  output logic            push,
  output pps_pkg::item_t  item
);

  logic known;

  assign busy = q_full;

  always_comb begin
    item.proc_id    = proc_id;
    item.arrival    = arrival_time;
    item.burst      = burst_time;
    item.prio       = priority_level;
    item.zero_burst = (burst_time == 16'd0);
    known           = 1'b1;
    case (kind)
      pps_pkg::KIND_LOAD:  item.op = pps_pkg::OP_LOAD;
      pps_pkg::KIND_STEP:  item.op = pps_pkg::OP_STEP;
      pps_pkg::KIND_CLEAR: item.op = pps_pkg::OP_CLEAR;
      default: begin
        // unknown kind is dropped at the door
        item.op = pps_pkg::OP_STEP;
        known   = 1'b0;
      end
    endcase
  end

  assign push = start && !q_full && known;

endmodule

[sv/pps_back.sv]
module pps_back #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  pps_pkg::item_t  item,
  input  logic            q_empty,
  output logic            pop,
  input  logic [7:0]      switch_time,
  output pps_pkg::res_t   res
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic [15:0] arrival_mem [MAX_PROCS];
  logic [15:0] remain_mem  [MAX_PROCS];
  logic [7:0]  prio_mem    [MAX_PROCS];
  logic [7:0]  id_mem      [MAX_PROCS];

  pps_pkg::bstate_t state, state_next;

  logic [CW-1:0] loaded;
  logic [CW-1:0] done_cnt;
  logic [15:0]   now;
  logic          last_valid;
  logic [7:0]    last_id;
  logic [15:0]   switches;
  logic [15:0]   overhead;

  logic [CW-1:0] cnt;
  logic          rv;
  logic [IW-1:0] rd_idx;
  logic          found;

  logic [15:0]   rd_arr;
  logic [15:0]   rd_rem;
  logic [7:0]    rd_pri;
  logic [7:0]    rd_id;

  logic [IW-1:0] best_idx;
  logic [15:0]   best_arr;
  logic [15:0]   best_rem;
  logic [7:0]    best_pri;
  logic [7:0]    best_id;

  logic          valid_q;
  pps_pkg::res_t res_q;

  logic          can_load;
  logic          all_done;
  logic          we_load;
  logic          we_exec;
  logic          rd_ready;
  logic          rd_better;
  logic          take;
  logic          scan_more;

  logic          sw;
  logic [15:0]   now1;
  logic [15:0]   now2;
  logic [15:0]   now_idle;
  logic [15:0]   rem_dec;
  logic          fin;
  logic [15:0]   switches_new;
  logic [15:0]   overhead_new;

  assign can_load  = (loaded < CW'(MAX_PROCS));
  assign all_done  = (done_cnt >= loaded);
  assign scan_more = (cnt < loaded);

  assign we_load = (state == pps_pkg::B_IDLE) && !q_empty &&
                   (item.op == pps_pkg::OP_LOAD) && can_load;
  assign we_exec = (state == pps_pkg::B_EXEC) && found;

  // scan compare on the registered read of the previous address
  assign rd_ready  = (rd_arr <= now) && (rd_rem != 16'd0);
  assign rd_better = !found || (rd_pri > best_pri) ||
                     ((rd_pri == best_pri) && (rd_arr < best_arr));
  assign take      = (state == pps_pkg::B_SCAN) && rv && rd_ready && rd_better;

  assign sw           = last_valid && (last_id != best_id);
  assign now1         = sw ? pps_pkg::sat_add16(now, {8'd0, switch_time}) : now;
  assign now2         = pps_pkg::sat_add16(now1, 16'd1);
  assign now_idle     = pps_pkg::sat_add16(now, 16'd1);
  assign rem_dec      = best_rem - 16'd1;
  assign fin          = (rem_dec == 16'd0);
  assign switches_new = sw ? pps_pkg::sat_add16(switches, 16'd1) : switches;
  assign overhead_new = sw ? pps_pkg::sat_add16(overhead, {8'd0, switch_time}) : overhead;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    case (state)
      pps_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          if (item.op == pps_pkg::OP_STEP && !all_done) begin
            state_next = pps_pkg::B_SCAN;
          end
        end
      end
      pps_pkg::B_SCAN: begin
        if (!scan_more && !rv) begin
          state_next = pps_pkg::B_EXEC;
        end
      end
      pps_pkg::B_EXEC: state_next = pps_pkg::B_IDLE;
      default:         state_next = pps_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= '0;
      done_cnt   <= '0;
      now        <= '0;
      last_valid <= 1'b0;
      last_id    <= '0;
      switches   <= '0;
      overhead   <= '0;
      cnt        <= '0;
      rv         <= 1'b0;
      found      <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state)
        pps_pkg::B_IDLE: begin
          if (!q_empty) begin
            case (item.op)
              pps_pkg::OP_LOAD: begin
                if (can_load) begin
                  loaded <= loaded + 1'b1;
                  if (item.zero_burst) begin
                    done_cnt <= done_cnt + 1'b1;
                  end
                end
              end
              pps_pkg::OP_CLEAR: begin
                loaded     <= '0;
                done_cnt   <= '0;
                now        <= '0;
                last_valid <= 1'b0;
                last_id    <= '0;
                switches   <= '0;
                overhead   <= '0;
              end
              pps_pkg::OP_STEP: begin
                if (all_done) begin
                  valid_q <= 1'b1;
                end else begin
                  cnt   <= '0;
                  rv    <= 1'b0;
                  found <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        pps_pkg::B_SCAN: begin
          if (scan_more) begin
            cnt <= cnt + 1'b1;
          end
          rv <= scan_more;
          if (take) begin
            found <= 1'b1;
          end
        end
        pps_pkg::B_EXEC: begin
          valid_q <= 1'b1;
          if (found) begin
            now        <= now2;
            last_valid <= 1'b1;
            last_id    <= best_id;
            switches   <= switches_new;
            overhead   <= overhead_new;
            if (fin) begin
              done_cnt <= done_cnt + 1'b1;
            end
          end else begin
            now        <= now_idle;
            last_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we_load) begin
      arrival_mem[loaded[IW-1:0]] <= item.arrival;
      remain_mem[loaded[IW-1:0]]  <= item.burst;
      prio_mem[loaded[IW-1:0]]    <= item.prio;
      id_mem[loaded[IW-1:0]]      <= item.proc_id;
    end else if (we_exec) begin
      remain_mem[best_idx] <= rem_dec;
    end
    rd_arr <= arrival_mem[cnt[IW-1:0]];
    rd_rem <= remain_mem[cnt[IW-1:0]];
    rd_pri <= prio_mem[cnt[IW-1:0]];
    rd_id  <= id_mem[cnt[IW-1:0]];
    rd_idx <= cnt[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= rd_idx;
      best_arr <= rd_arr;
      best_rem <= rd_rem;
      best_pri <= rd_pri;
      best_id  <= rd_id;
    end
    if (state == pps_pkg::B_IDLE) begin
      res_q              <= '0;
      res_q.event_res    <= pps_pkg::EV_ALLDONE;
      res_q.switch_count <= switches;
      res_q.switch_total <= overhead;
    end else if (state == pps_pkg::B_EXEC) begin
      res_q <= '0;
      if (found) begin
        res_q.event_res    <= pps_pkg::EV_RAN;
        res_q.switched     <= sw;
        res_q.switch_start <= sw ? now : 16'd0;
        res_q.slot         <= 4'(best_idx);
        res_q.run_id       <= best_id;
        res_q.event_time   <= now1;
        res_q.finished     <= fin;
        res_q.turnaround   <= fin ? (now2 - best_arr) : 16'd0;
        res_q.switch_count <= switches_new;
        res_q.switch_total <= overhead_new;
      end else begin
        res_q.event_res    <= pps_pkg::EV_IDLE;
        res_q.event_time   <= now_idle;
        res_q.switch_count <= switches;
        res_q.switch_total <= overhead;
      end
    end
  end

  always_comb begin
    res       = res_q;
    res.valid = valid_q;
  end

endmodule

[sv/preemptive_priority_scheduler.sv]
// Load and clear: handled by the back end once at the head of the queue, no result.
// Step: the back end scans the table, reading one entry per cycle, then executes and
// strobes a result (straight from idle when the table is empty or all finished); a step
// occupies the back end until its scan and execution are done.
// busy rises only while the two-entry queue is full. The receiver cannot stall.
// Synchronous reset empties the table and queue, zeroes time and counters, switch_time = 1.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  proc_id,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_time,
  input  logic [7:0]  priority_level,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        done,
  output logic [1:0]  event_res,
  output logic        switched,
  output logic [15:0] switch_start,
  output logic [3:0]  slot,
  output logic [7:0]  run_id,
  output logic [15:0] event_time,
  output logic        finished,
  output logic [15:0] turnaround,
  output logic [15:0] switch_count,
  output logic [15:0] switch_total
);

  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  pps_pkg::item_t item_in;
  pps_pkg::item_t item_out;
  pps_pkg::res_t  res;
  logic [7:0]     switch_time;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_time <= pps_pkg::SWITCH_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      switch_time <= cfg_data;
    end
  end

  pps_front u_front (
    .start          (start),
    .kind           (kind),
    .proc_id        (proc_id),
    .arrival_time   (arrival_time),
    .burst_time     (burst_time),
    .priority_level (priority_level),
    .q_full         (q_full),
    .busy           (busy),
    .push           (push),
    .item           (item_in)
  );

  pps_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (item_in),
    .pop   (pop),
    .dout  (item_out),
    .empty (q_empty),
    .full  (q_full)
  );

  pps_back #(
    .MAX_PROCS (MAX_PROCS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (item_out),
    .q_empty     (q_empty),
    .pop         (pop),
    .switch_time (switch_time),
    .res         (res)
  );

  assign done         = res.valid;
  assign event_res    = res.event_res;
  assign switched     = res.switched;
  assign switch_start = res.switch_start;
  assign slot         = res.slot;
  assign run_id       = res.run_id;
  assign event_time   = res.event_time;
  assign finished     = res.finished;
  assign turnaround   = res.turnaround;
  assign switch_count = res.switch_count;
  assign switch_total = res.switch_total;

endmodule

[sv/pps_checker.sv]
module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [1:0]  event_res,
  input logic        switched,
  input logic        finished,
  input logic [7:0]  run_id,
  input logic [15:0] switch_count
);

  // only the three defined event codes ever appear
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (event_res == pps_pkg::EV_IDLE || event_res == pps_pkg::EV_RAN ||
              event_res == pps_pkg::EV_ALLDONE))
    else $error("undefined event code on result");

  a_alldone_clean: assert property (@(posedge clk) disable iff (rst)
    (done && event_res == pps_pkg::EV_ALLDONE) |-> (!switched && !finished && run_id == 8'd0))
    else $error("all-finished result carries run data");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (done && event_res == pps_pkg::EV_IDLE) |-> (!switched && !finished && run_id == 8'd0))
    else $error("idle result carries run data");

  // a counted switch means the counter is nonzero in the same transaction
  a_switch_counted: assert property (@(posedge clk) disable iff (rst)
    (done && switched) |-> (event_res == pps_pkg::EV_RAN && switch_count != 16'd0))
    else $error("switch flagged without a run or a count");

endmodule

bind preemptive_priority_scheduler pps_checker u_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

typedef struct packed {
  logic [1:0]  event_res;
  logic        switched;
  logic [15:0] switch_start;
  logic [3:0]  slot;
  logic [7:0]  run_id;
  logic [15:0] event_time;
  logic        finished;
  logic [15:0] turnaround;
  logic [15:0] switch_count;
  logic [15:0] switch_total;
} decision_t;

// Mirrors the process table and predicts each scheduling decision.
class sched_tracker;
  localparam int SLOTS = 16;

  logic [15:0] arr_tab [SLOTS];
  logic [15:0] left_tab [SLOTS];
  logic [7:0]  prio_tab [SLOTS];
  logic [7:0]  id_tab [SLOTS];
  int          loaded;
  int          done_cnt;
  logic [15:0] now_t;
  bit          last_ran;
  logic [7:0]  last_pid;
  logic [15:0] sw_count;
  logic [15:0] sw_total;
  logic [7:0]  sw_time;
  decision_t   due_decisions[$];
  int          errors;

  function new();
    sw_time = pps_pkg::SWITCH_TIME_RST;
    errors = 0;
    wipe();
  endfunction

  function void wipe();
    foreach (arr_tab[i]) begin
      arr_tab[i] = '0;
      left_tab[i] = '0;
      prio_tab[i] = '0;
      id_tab[i] = '0;
    end
    loaded = 0;
    done_cnt = 0;
    now_t = '0;
    last_ran = 1'b0;
    last_pid = '0;
    sw_count = '0;
    sw_total = '0;
  endfunction

  function logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
    int s;
    s = int'(a) + int'(b);
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function void set_switch_time(logic [7:0] v);
    sw_time = v;
  endfunction

  function bit all_finished();
    return done_cnt >= loaded;
  endfunction

  function int pending();
    return due_decisions.size();
  endfunction

  // Called once per transaction taken at the front end, in acceptance order; unknown kinds are ignored.
  function void take_item(logic [1:0] k, logic [7:0] pid, logic [15:0] arr,
                          logic [15:0] bur, logic [7:0] pr);
    decision_t r;
    int        pick;
    bit        found;
    r = '0;
    pick = 0;
    found = 1'b0;
    case (k)
      pps_pkg::KIND_LOAD: begin
        if (loaded < SLOTS) begin
          id_tab[loaded] = pid;
          arr_tab[loaded] = arr;
          left_tab[loaded] = bur;
          prio_tab[loaded] = pr;
          if (bur == 0) done_cnt++;
          loaded++;
        end
      end
      pps_pkg::KIND_CLEAR: wipe();
      pps_pkg::KIND_STEP: begin
        if (done_cnt >= loaded) begin
          r.event_res = pps_pkg::EV_ALLDONE;
        end else begin
          for (int i = 0; i < loaded; i++) begin
            if (arr_tab[i] <= now_t && left_tab[i] != 0) begin
              if (!found || prio_tab[i] > prio_tab[pick] ||
                  (prio_tab[i] == prio_tab[pick] && arr_tab[i] < arr_tab[pick])) begin
                pick = i;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            r.event_res = pps_pkg::EV_RAN;
            if (last_ran && last_pid != id_tab[pick]) begin
              sw_count = sat16(sw_count, 16'd1);
              sw_total = sat16(sw_total, {8'd0, sw_time});
              r.switched = 1'b1;
              r.switch_start = now_t;
              now_t = sat16(now_t, {8'd0, sw_time});
            end
            r.slot = pick[3:0];
            r.run_id = id_tab[pick];
            r.event_time = now_t;
            left_tab[pick] = left_tab[pick] - 16'd1;
            now_t = sat16(now_t, 16'd1);
            last_ran = 1'b1;
            last_pid = id_tab[pick];
            if (left_tab[pick] == 0) begin
              done_cnt++;
              r.finished = 1'b1;
              r.turnaround = now_t - arr_tab[pick];
            end
          end else begin
            // nothing ready: one idle tick, next run counts no switch
            now_t = sat16(now_t, 16'd1);
            last_ran = 1'b0;
            r.event_res = pps_pkg::EV_IDLE;
            r.event_time = now_t;
          end
        end
        r.switch_count = sw_count;
        r.switch_total = sw_total;
        due_decisions.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function void check_field(string name, int want, int seen);
    if (want != seen) begin
      errors++;
      $display("%0t %s: expected %0d, actual %0d", $time, name, want, seen);
    end
  endfunction

  function void check_decision(decision_t got);
    decision_t want;
    if (due_decisions.size() == 0) begin
      errors++;
      $display("%0t unexpected decision: event_res %0d run_id %0d", $time,
               got.event_res, got.run_id);
      return;
    end
    want = due_decisions.pop_front();
    check_field("event_res", want.event_res, got.event_res);
    check_field("switched", want.switched, got.switched);
    check_field("switch_start", want.switch_start, got.switch_start);
    check_field("slot", want.slot, got.slot);
    check_field("run_id", want.run_id, got.run_id);
    check_field("event_time", want.event_time, got.event_time);
    check_field("finished", want.finished, got.finished);
    check_field("turnaround", want.turnaround, got.turnaround);
    check_field("switch_count", want.switch_count, got.switch_count);
    check_field("switch_total", want.switch_total, got.switch_total);
  endfunction
endclass

module testbench;
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE = 40;
  localparam int PHASE_ITEMS = 235;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [7:0]  proc_id;
  logic [15:0] arrival_time;
  logic [15:0] burst_time;
  logic [7:0]  priority_level;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;
  logic        done;
  logic [1:0]  event_res;
  logic        switched;
  logic [15:0] switch_start;
  logic [3:0]  slot;
  logic [7:0]  run_id;
  logic [15:0] event_time;
  logic        finished;
  logic [15:0] turnaround;
  logic [15:0] switch_count;
  logic [15:0] switch_total;

  sched_tracker sb;
  decision_t    seen_res;
  int           idle_pct = 0;
  int           items = 0;
  int           cycles = 0;
  int           st_set [4];
  int           pct_set [4];

  preemptive_priority_scheduler u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .kind           (kind),
    .proc_id        (proc_id),
    .arrival_time   (arrival_time),
    .burst_time     (burst_time),
    .priority_level (priority_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .done           (done),
    .event_res      (event_res),
    .switched       (switched),
    .switch_start   (switch_start),
    .slot           (slot),
    .run_id         (run_id),
    .event_time     (event_time),
    .finished       (finished),
    .turnaround     (turnaround),
    .switch_count   (switch_count),
    .switch_total   (switch_total)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_res = {event_res, switched, switch_start, slot, run_id, event_time, finished,
                  turnaround, switch_count, switch_total};
      sb.check_decision(seen_res);
    end
  end

  // Holds start until the transaction is taken, then maybe idles a while.
  task automatic send_item(logic [1:0] k, logic [7:0] pid, logic [15:0] arr,
                           logic [15:0] bur, logic [7:0] pr);
    start <= 1'b1;
    kind <= k;
    proc_id <= pid;
    arrival_time <= arr;
    burst_time <= bur;
    priority_level <= pr;
    do @(posedge clk); while (busy);
    if (k == pps_pkg::KIND_STEP || k == pps_pkg::KIND_CLEAR ||
        (k == pps_pkg::KIND_LOAD && sb.loaded < 16)) items++;
    sb.take_item(k, pid, arr, bur, pr);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic send_step();
    send_item(pps_pkg::KIND_STEP, 8'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  // Loads and clears give no result, so allow the back end to drain too.
  task automatic quiesce();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_switch_time(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_switch_time(v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_load();
    logic [7:0]  pid;
    logic [15:0] arr;
    logic [15:0] bur;
    logic [7:0]  pr;
    pid = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom);
    arr = ($urandom_range(0, 11) == 0) ? 16'($urandom)
                                        : 16'(sb.now_t + $urandom_range(0, 15));
    case ($urandom_range(0, 29))
      0, 1: bur = 16'($urandom);
      2:    bur = '0;
      default: bur = 16'($urandom_range(1, 6));
    endcase
    pr = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    send_item(pps_pkg::KIND_LOAD, pid, arr, bur, pr);
  endtask

  // Mostly: fill a table, then step it until everything has run or 60 steps are sent.
  task automatic random_sequence();
    int n;
    int steps;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(2'($urandom_range(0, 2)), 8'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom));
    end else begin
      if ($urandom_range(0, 4) != 0)
        send_item(pps_pkg::KIND_CLEAR, 8'($urandom), 16'($urandom), 16'($urandom),
                  8'($urandom));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 8);
      repeat (n) random_load();
      steps = 0;
      while (!sb.all_finished() && steps < 60) begin
        send_step();
        steps++;
      end
      repeat ($urandom_range(0, 2)) send_step();
    end
  endtask

  task automatic directed();
    send_item(pps_pkg::KIND_STEP, 8'h00, 16'h0000, 16'h0000, 8'h00);   // empty table
    send_item(pps_pkg::KIND_LOAD, 8'hFF, 16'h0000, 16'h0000, 8'h00);   // zero burst
    send_item(pps_pkg::KIND_STEP, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_item(KIND_SPARE, 8'h12, 16'h0003, 16'h0004, 8'h05);           // unused kind
    send_item(pps_pkg::KIND_LOAD, 8'h00, 16'h0002, 16'h0002, 8'hFF);
    send_item(pps_pkg::KIND_LOAD, 8'hAA, 16'h0000, 16'h0001, 8'h00);
    send_item(pps_pkg::KIND_LOAD, 8'h55, 16'h0000, 16'h0003, 8'h00);   // tie with slot above
    send_item(pps_pkg::KIND_LOAD, 8'h80, 16'hFFFF, 16'hFFFF, 8'hFF);   // never arrives here
    repeat (9) send_step();
    send_item(pps_pkg::KIND_CLEAR, 8'h00, 16'h0000, 16'h0000, 8'h00);
    send_step();
  endtask

  initial begin
    sb = new();
    start <= 1'b0;
    kind <= pps_pkg::KIND_LOAD;
    proc_id <= '0;
    arrival_time <= '0;
    burst_time <= '0;
    priority_level <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    st_set = '{0, 255, 0, 1};
    st_set[2] = $urandom_range(2, 254);
    pct_set = '{0, 56, 0, 15};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    for (int p = 0; p < 4; p++) begin
      quiesce();
      write_switch_time(8'(st_set[p]));
      idle_pct = pct_set[p];
      while (items < (p + 1) * PHASE_ITEMS) random_sequence();
    end

    quiesce();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[sim.f]
sv/pps_pkg.sv
sv/pps_queue.sv
sv/pps_front.sv
sv/pps_back.sv
sv/preemptive_priority_scheduler.sv
sv/pps_checker.sv
tb/testbench.sv
